// ----- rtl/grid_local_minimum_risk_sum_core_macros.svh -----
// Assertion macros used by the checker file of the low-point core.
// Plain text only; no dependencies.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_CORE_MACROS_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_CORE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define GLMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define GLMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/glmr_pkg.sv -----
// Shared widths, config codes and the front-to-back token type of the low-point core.
// No dependencies.
package glmr_pkg;

  localparam int HEIGHT_W     = 4;
  localparam int CELL_ROW_W   = 12;
  localparam int CELL_COL_W   = 8;
  localparam int RISK_ADD_W   = 4;
  localparam int RISK_TOTAL_W = 23;

  localparam int CFG_COLS_W = 9;
  localparam int CFG_ROWS_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'd1;

  localparam int COLS_RESET = 256;
  localparam int ROWS_RESET = 4096;

  // line buffers rotate between current row, row above, two rows above
  localparam int LB_COUNT    = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [RISK_TOTAL_W-1:0] RISK_MAX = {RISK_TOTAL_W{1'b1}};
  localparam logic [RISK_ADD_W-1:0]   RISK_SAT = {RISK_ADD_W{1'b1}};

  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic has_right;
    logic last_row;
    logic final_cell;
  } glmr_flags_t;

  // One accepted cell plus its line-buffer neighbors.
  typedef struct packed {
    logic [HEIGHT_W-1:0]   height;
    logic [HEIGHT_W-1:0]   above;
    logic [HEIGHT_W-1:0]   above2;
    logic [HEIGHT_W-1:0]   above_right;
    logic [CELL_ROW_W-1:0] row;
    logic [CELL_COL_W-1:0] col;
    glmr_flags_t           flags;
  } glmr_token_t;

endpackage

// ----- rtl/glmr_front.sv -----
// Front end: input handshake, grid counters, config registers, three rotating line buffers.
// Depends on glmr_pkg; feeds glmr_queue.
module glmr_front #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [glmr_pkg::HEIGHT_W-1:0]    in_height,
  input  logic                             cfg_we,
  input  logic [glmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glmr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             q_full,
  output logic                             q_push,
  output glmr_pkg::glmr_token_t            q_token
);
  import glmr_pkg::*;

  localparam int COL_CAP   = (1 << CFG_COLS_W) - 1;
  localparam int COL_LIMIT = (MAX_COLUMNS < COL_CAP) ? MAX_COLUMNS : COL_CAP;
  localparam int CW        = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
  localparam int COL_RESET = (COLS_RESET < COL_LIMIT) ? COLS_RESET : COL_LIMIT;
  localparam logic [CFG_COLS_W-1:0] COL_LIMIT_V  = CFG_COLS_W'(COL_LIMIT);
  localparam logic [CW-1:0]         COL_LIMIT_M1 = CW'(COL_LIMIT - 1);
  localparam logic [CW-1:0]         COL_RESET_M1 = CW'(COL_RESET - 1);

  localparam int ROW_CAP   = (1 << CFG_ROWS_W) - 1;
  localparam int ROW_LIMIT = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;
  localparam int RW        = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
  localparam int ROW_RESET = (ROWS_RESET < ROW_LIMIT) ? ROWS_RESET : ROW_LIMIT;
  localparam logic [CFG_ROWS_W-1:0] ROW_LIMIT_V  = CFG_ROWS_W'(ROW_LIMIT);
  localparam logic [RW-1:0]         ROW_LIMIT_M1 = RW'(ROW_LIMIT - 1);
  localparam logic [RW-1:0]         ROW_RESET_M1 = RW'(ROW_RESET - 1);

  localparam logic [1:0] ROLE_LAST = 2'(LB_COUNT - 1);

  logic                  in_fire;
  logic [CFG_COLS_W-1:0] cfg_cols;
  logic [CFG_ROWS_W-1:0] cfg_rows;
  logic [CW-1:0]         cols_clamp_m1;
  logic [RW-1:0]         rows_clamp_m1;
  logic [CW-1:0]         cols_m1_r, cols_m1_nxt;
  logic [RW-1:0]         rows_m1_r, rows_m1_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [1:0]            role_r, role_nxt;
  logic [CW-1:0]         addr_right;
  glmr_flags_t           acc_flags;

  logic                  s1_v_r, s1_v_nxt;
  logic [HEIGHT_W-1:0]   s1_height_r;
  logic [RW-1:0]         s1_row_r;
  logic [CW-1:0]         s1_col_r;
  logic [1:0]            s1_role_r;
  glmr_flags_t           s1_flags_r;

  logic [HEIGHT_W-1:0]   rd_col   [LB_COUNT];
  logic [HEIGHT_W-1:0]   rd_right [LB_COUNT];

  assign in_ready = !s1_v_r || !q_full;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = s1_v_r && !q_full;

  // size registers hold size-1, zero acts as one, oversize acts as the limit
  assign cfg_cols = cfg_wdata[CFG_COLS_W-1:0];
  assign cfg_rows = cfg_wdata[CFG_ROWS_W-1:0];
  assign cols_clamp_m1 = (cfg_cols == '0) ? '0 :
                         (cfg_cols > COL_LIMIT_V) ? COL_LIMIT_M1 :
                         CW'(cfg_cols - CFG_COLS_W'(1));
  assign rows_clamp_m1 = (cfg_rows == '0) ? '0 :
                         (cfg_rows > ROW_LIMIT_V) ? ROW_LIMIT_M1 :
                         RW'(cfg_rows - CFG_ROWS_W'(1));

  always_comb begin
    cols_m1_nxt = cols_m1_r;
    rows_m1_nxt = rows_m1_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_COLS: cols_m1_nxt = cols_clamp_m1;
        CFG_IDX_ROWS: rows_m1_nxt = rows_clamp_m1;
      endcase
    end
  end

  always_comb begin
    acc_flags.row_ge1    = (row_r != '0);
    acc_flags.row_ge2    = (row_r > RW'(1));
    acc_flags.col_ge1    = (col_r != '0);
    acc_flags.col_ge2    = (col_r > CW'(1));
    acc_flags.has_right  = (col_r != cols_m1_r);
    acc_flags.last_row   = (row_r == rows_m1_r);
    acc_flags.final_cell = acc_flags.last_row && !acc_flags.has_right;
  end

  assign addr_right = acc_flags.has_right ? col_r + CW'(1) : col_r;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    role_nxt = role_r;
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      role_nxt = '0;
    end else if (in_fire) begin
      if (acc_flags.has_right) begin
        col_nxt = col_r + CW'(1);
      end else begin
        col_nxt = '0;
        if (acc_flags.last_row) begin
          row_nxt  = '0;
          role_nxt = '0;
        end else begin
          row_nxt  = row_r + RW'(1);
          role_nxt = (role_r == ROLE_LAST) ? 2'd0 : role_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (q_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r <= COL_RESET_M1;
      rows_m1_r <= ROW_RESET_M1;
      col_r     <= '0;
      row_r     <= '0;
      role_r    <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      cols_m1_r <= cols_m1_nxt;
      rows_m1_r <= rows_m1_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      role_r    <= role_nxt;
      s1_v_r    <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_height_r <= in_height;
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
      s1_role_r   <= role_r;
      s1_flags_r  <= acc_flags;
    end
  end

  // Current row writes its own buffer; all three are read at col and col+1 (col at the row end).
  for (genvar gi = 0; gi < LB_COUNT; gi++) begin : g_lb
    logic [HEIGHT_W-1:0] lb_mem [COL_LIMIT];

    always_ff @(posedge clk) begin
      if (in_fire && (role_r == 2'(gi))) begin
        lb_mem[col_r] <= in_height;
      end
      if (in_fire) begin
        rd_col[gi]   <= lb_mem[col_r];
        rd_right[gi] <= lb_mem[addr_right];
      end
    end
  end

  always_comb begin
    q_token.height = s1_height_r;
    q_token.row    = CELL_ROW_W'(s1_row_r);
    q_token.col    = CELL_COL_W'(s1_col_r);
    q_token.flags  = s1_flags_r;
    case (s1_role_r)
      2'd0: begin
        q_token.above       = rd_col[2];
        q_token.above2      = rd_col[1];
        q_token.above_right = rd_right[2];
      end
      2'd1: begin
        q_token.above       = rd_col[0];
        q_token.above2      = rd_col[2];
        q_token.above_right = rd_right[0];
      end
      default: begin
        q_token.above       = rd_col[1];
        q_token.above2      = rd_col[0];
        q_token.above_right = rd_right[1];
      end
    endcase
  end

endmodule

// ----- rtl/glmr_queue.sv -----
// Small FIFO of cell tokens between the front end and the decision unit.
// Depends on glmr_pkg.
module glmr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  glmr_pkg::glmr_token_t push_token,
  output logic                  full,
  output logic                  head_valid,
  output glmr_pkg::glmr_token_t head_token,
  input  logic                  pop
);
  import glmr_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);

  glmr_token_t      entry_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]     count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == (QPW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_token = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

// ----- rtl/glmr_back.sv -----
// Decision unit: turns each token into zero to three low-point results, keeps the risk sum.
// Depends on glmr_pkg; drains glmr_queue, drives the result register.
module glmr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                head_valid,
  input  glmr_pkg::glmr_token_t               head_token,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [glmr_pkg::CELL_ROW_W-1:0]     out_cell_row,
  output logic [glmr_pkg::CELL_COL_W-1:0]     out_cell_column,
  output logic                                out_is_low_point,
  output logic [glmr_pkg::RISK_ADD_W-1:0]     out_risk_added,
  output logic [glmr_pkg::RISK_TOTAL_W-1:0]   out_risk_total,
  output logic                                out_grid_done
);
  import glmr_pkg::*;

  // which cell the current result is about
  localparam logic [1:0] DEC_ROW_ABOVE = 2'd0;  // cell above the new one
  localparam logic [1:0] DEC_LEFT_CELL = 2'd1;  // last row: cell left of the new one
  localparam logic [1:0] DEC_HERE      = 2'd2;  // final cell itself

  logic [2:0]              need;
  logic [2:0]              rem;
  logic [2:0]              sel_bit;
  logic                    rem_last;
  logic                    out_space;
  logic                    emit;
  logic [1:0]              dec_sel;

  logic [HEIGHT_W-1:0]     self_h;
  logic [HEIGHT_W-1:0]     nb [4];
  logic [3:0]              has;
  logic [CELL_ROW_W-1:0]   dec_row;
  logic [CELL_COL_W-1:0]   dec_col;
  logic                    dec_done;
  logic                    low;
  logic [RISK_ADD_W:0]     risk_inc;
  logic [RISK_ADD_W-1:0]   risk;
  logic [RISK_TOTAL_W:0]   sum_wide;
  logic [RISK_TOTAL_W-1:0] sum_sat;

  logic [2:0]              done_r, done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RISK_TOTAL_W-1:0] risk_sum_r, risk_sum_nxt;
  logic [HEIGHT_W-1:0]     prev_above_r;
  logic [HEIGHT_W-1:0]     h1_r;
  logic [HEIGHT_W-1:0]     h2_r;
  logic [CELL_ROW_W-1:0]   out_row_r;
  logic [CELL_COL_W-1:0]   out_col_r;
  logic                    out_low_r;
  logic [RISK_ADD_W-1:0]   out_add_r;
  logic [RISK_TOTAL_W-1:0] out_total_r;
  logic                    out_done_r;

  assign need = {head_token.flags.final_cell,
                 head_token.flags.last_row && head_token.flags.col_ge1,
                 head_token.flags.row_ge1};
  assign rem      = need & ~done_r;
  assign sel_bit  = rem & (~rem + 3'd1);
  assign rem_last = ((rem & (rem - 3'd1)) == 3'd0);
  assign out_space = !out_valid_r || out_ready;
  assign emit     = head_valid && (rem != 3'd0) && out_space;
  assign pop      = head_valid && ((rem == 3'd0) || (emit && rem_last));
  assign dec_sel  = rem[0] ? DEC_ROW_ABOVE : (rem[1] ? DEC_LEFT_CELL : DEC_HERE);

  // neighbor order: above, left, right, below
  always_comb begin
    self_h   = head_token.height;
    nb[0]    = '0;
    nb[1]    = '0;
    nb[2]    = '0;
    nb[3]    = '0;
    has      = 4'b0000;
    dec_row  = head_token.row;
    dec_col  = head_token.col;
    dec_done = 1'b0;
    unique case (dec_sel)
      DEC_ROW_ABOVE: begin
        self_h  = head_token.above;
        nb[0]   = head_token.above2;
        nb[1]   = prev_above_r;
        nb[2]   = head_token.above_right;
        nb[3]   = head_token.height;
        has     = {1'b1, head_token.flags.has_right, head_token.flags.col_ge1,
                   head_token.flags.row_ge2};
        dec_row = head_token.row - CELL_ROW_W'(1);
      end
      DEC_LEFT_CELL: begin
        self_h  = h1_r;
        nb[0]   = prev_above_r;
        nb[1]   = h2_r;
        nb[2]   = head_token.height;
        has     = {1'b0, 1'b1, head_token.flags.col_ge2, head_token.flags.row_ge1};
        dec_col = head_token.col - CELL_COL_W'(1);
      end
      DEC_HERE: begin
        nb[0]    = head_token.above;
        nb[1]    = h1_r;
        has      = {2'b00, head_token.flags.col_ge1, head_token.flags.row_ge1};
        dec_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    low = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (has[i] && !(self_h < nb[i])) begin
        low = 1'b0;
      end
    end
  end

  assign risk_inc = {1'b0, self_h} + (RISK_ADD_W+1)'(1);
  assign risk     = !low ? '0 : (risk_inc[RISK_ADD_W] ? RISK_SAT : risk_inc[RISK_ADD_W-1:0]);
  assign sum_wide = {1'b0, risk_sum_r} + (RISK_TOTAL_W+1)'(risk);
  assign sum_sat  = sum_wide[RISK_TOTAL_W] ? RISK_MAX : sum_wide[RISK_TOTAL_W-1:0];

  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    risk_sum_nxt  = risk_sum_r;
    if (pop) begin
      done_nxt = 3'd0;
    end else if (emit) begin
      done_nxt = done_r | sel_bit;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (restart) begin
      risk_sum_nxt = '0;
    end else if (emit) begin
      risk_sum_nxt = dec_done ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 3'd0;
      out_valid_r <= 1'b0;
      risk_sum_r  <= '0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      risk_sum_r  <= risk_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= dec_row;
      out_col_r   <= dec_col;
      out_low_r   <= low;
      out_add_r   <= risk;
      out_total_r <= sum_sat;
      out_done_r  <= dec_done;
    end
    if (pop) begin
      prev_above_r <= head_token.above;
      h2_r         <= h1_r;
      h1_r         <= head_token.height;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_row     = out_row_r;
  assign out_cell_column  = out_col_r;
  assign out_is_low_point = out_low_r;
  assign out_risk_added   = out_add_r;
  assign out_risk_total   = out_total_r;
  assign out_grid_done    = out_done_r;

endmodule

// ----- rtl/grid_local_minimum_risk_sum_core.sv -----
// Top level of the streaming 4-neighbor low-point detector with running risk sum.
// Depends on glmr_pkg, glmr_front, glmr_queue, glmr_back.
//
// Usage:
//  - in_valid/in_ready/in_height: one height digit per beat, row-major order.
//  - out_valid/out_ready/out_*: one decided cell per beat. A cell is decided when
//    its last neighbor arrives: one row later, or one beat later in the last row.
//    The grid's final beat yields up to three results; the last has grid_done set.
//  - cfg_we/cfg_index/cfg_wdata: grid columns (index 0) and rows (index 1); a size
//    of zero acts as one, oversize acts as the parameter limit. Any write restarts
//    the grid and clears the risk sum. Write only while idle.
//  - Path: front-end stage, token queue, decision unit, result register.
//  - Throughput: one beat per cycle while the queue has room; in the last row a
//    beat makes up to two results, the final beat up to three. The single result
//    register and decision unit set the pace: one result per cycle unless stalled.
//  - Receiver stall: the result register holds; the 4-entry token queue and the
//    front-end stage absorb up to five result-owing beats before in_ready drops.
//  - Reset: counters at zero, grid 256 x 4096 (clamped to the parameters). The
//    line buffers need no clearing pass; an entry's value is used only after this
//    grid has written it.
module grid_local_minimum_risk_sum_core #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [glmr_pkg::HEIGHT_W-1:0]       in_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [glmr_pkg::CELL_ROW_W-1:0]     out_cell_row,
  output logic [glmr_pkg::CELL_COL_W-1:0]     out_cell_column,
  output logic                                out_is_low_point,
  output logic [glmr_pkg::RISK_ADD_W-1:0]     out_risk_added,
  output logic [glmr_pkg::RISK_TOTAL_W-1:0]   out_risk_total,
  output logic                                out_grid_done,
  input  logic                                cfg_we,
  input  logic [glmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glmr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import glmr_pkg::*;

  // front end -> queue
  logic        q_push;
  logic        q_full;
  glmr_token_t q_token;
  // queue -> decision unit
  logic        head_valid;
  glmr_token_t head_token;
  logic        head_pop;

  // Counters, line buffers and config live in the front end; the buffer reads
  // land in its one-deep stage together with the cell they belong to.
  glmr_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_height (in_height),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_token   (q_token)
  );

  // Decouples the front (a token per cycle unless full) from the multi-result last row.
  glmr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (q_token),
    .full       (q_full),
    .head_valid (head_valid),
    .head_token (head_token),
    .pop        (head_pop)
  );

  // Emits each token's decisions in order, carries the left-hand history and
  // the saturating risk sum.
  glmr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (cfg_we),
    .head_valid       (head_valid),
    .head_token       (head_token),
    .pop              (head_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_row     (out_cell_row),
    .out_cell_column  (out_cell_column),
    .out_is_low_point (out_is_low_point),
    .out_risk_added   (out_risk_added),
    .out_risk_total   (out_risk_total),
    .out_grid_done    (out_grid_done)
  );

endmodule

// ----- rtl/glmr_checker.sv -----
// Port-level checks of the low-point core, bound to the top level.
// Depends on grid_local_minimum_risk_sum_core_macros.svh.
`include "grid_local_minimum_risk_sum_core_macros.svh"

module glmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_cell_row,
  input logic [7:0]  out_cell_column,
  input logic        out_is_low_point,
  input logic [3:0]  out_risk_added,
  input logic [22:0] out_risk_total,
  input logic        out_grid_done,
  input logic        cfg_we
);

  `GLMR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_row) && $stable(out_cell_column) && $stable(out_risk_total), "result beat changed while stalled")

  `GLMR_ASSERT_IMP(a_risk_flag, clk, rst_n, out_valid, out_is_low_point == (out_risk_added != 4'd0), "risk_added disagrees with low-point flag")

  `GLMR_ASSERT_IMP(a_risk_accum, clk, rst_n, out_valid && out_ready && $past(out_valid && out_ready && !out_grid_done && !cfg_we), (out_risk_total == $past(out_risk_total) + 23'(out_risk_added)) || (out_risk_total == 23'h7FFFFF), "risk total did not accumulate")

  `GLMR_ASSERT_IMP(a_grid_restart, clk, rst_n, out_valid && out_ready && $past(out_valid && out_ready && out_grid_done), out_risk_total == 23'(out_risk_added), "risk total not cleared after grid end")

endmodule

bind grid_local_minimum_risk_sum_core glmr_checker u_glmr_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for grid_local_minimum_risk_sum_core: a directed table, then random grids.
// Depends on glmr_pkg and the core RTL; expected beats come from a low-point predictor in here.
module tb_top;
  import glmr_pkg::*;

  localparam int MAX_COLS     = 256;
  localparam int MAX_ROWS_P   = 4096;
  localparam int RISK_CAP     = (1 << RISK_TOTAL_W) - 1;
  localparam int LAT_WAIT     = 8;     // drain wait for beats still in the front-end stage and queue
  localparam int HOLD_CYCLES  = 60;    // long receiver hold-off, well past the 5-beat buffering
  localparam int RANDOM_BEATS = 350;

  // One decided cell as it leaves the core.
  typedef struct {
    logic [CELL_ROW_W-1:0]   row;
    logic [CELL_COL_W-1:0]   col;
    logic                    low;
    logic [RISK_ADD_W-1:0]   risk;
    logic [RISK_TOTAL_W-1:0] total;
    logic                    done;
  } cell_result_t;

  typedef enum {ROW_CFG, ROW_BEAT} row_kind_t;
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // Directed table row: a register write or one height beat. typed_n < 0 means the
  // predictor supplies the expectation; 0 or 1 is the count of results typed in below.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [HEIGHT_W-1:0]   height;
    int                    typed_n;
    cell_result_t          typed;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [HEIGHT_W-1:0]     in_height = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CELL_ROW_W-1:0]   out_cell_row;
  logic [CELL_COL_W-1:0]   out_cell_column;
  logic                    out_is_low_point;
  logic [RISK_ADD_W-1:0]   out_risk_added;
  logic [RISK_TOTAL_W-1:0] out_risk_total;
  logic                    out_grid_done;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  grid_local_minimum_risk_sum_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_height        (in_height),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_row     (out_cell_row),
    .out_cell_column  (out_cell_column),
    .out_is_low_point (out_is_low_point),
    .out_risk_added   (out_risk_added),
    .out_risk_total   (out_risk_total),
    .out_grid_done    (out_grid_done),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Low-point predictor: own copy of the line buffers, counters and registers.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0]   line_two [MAX_COLS];
  logic [HEIGHT_W-1:0]   line_one [MAX_COLS];
  int                    col_pos;
  int                    row_pos;
  logic [HEIGHT_W-1:0]   left_cell;   // left neighbor of the next cell decided one row back
  int                    risk_acc;
  logic [CFG_COLS_W-1:0] cols_reg;
  logic [CFG_ROWS_W-1:0] rows_reg;
  cell_result_t          pending_cells [$];

  int           mismatches = 0;
  int           send_pct = 0;
  int           recv_pct = 0;
  bit           hold_request = 1'b0;
  int           hold_left = 0;
  int           beat_typed_n = -1;
  cell_result_t beat_typed;
  cell_result_t no_typed = '{default: '0};

  // Queue one expected result beat at the tail.
  task automatic expect_cell(input cell_result_t res);
    pending_cells = {pending_cells, res};
  endtask

  // Size of zero acts as one, oversize acts as the limit.
  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic restart_grid();
    col_pos   = 0;
    row_pos   = 0;
    left_cell = '0;
    risk_acc  = 0;
  endtask

  // Strict compare against each in-grid neighbor (top, left, right, bottom);
  // a low point adds its saturated risk to the saturated running total.
  function automatic cell_result_t judge_cell(
    int row, int col, logic [HEIGHT_W-1:0] self,
    logic ht, logic [HEIGHT_W-1:0] nt, logic hl, logic [HEIGHT_W-1:0] nl,
    logic hr, logic [HEIGHT_W-1:0] nr, logic hb, logic [HEIGHT_W-1:0] nb,
    logic done);
    cell_result_t res;
    logic         low;
    int           risk;
    low = 1'b1;
    if (ht && !(self < nt)) low = 1'b0;
    if (hl && !(self < nl)) low = 1'b0;
    if (hr && !(self < nr)) low = 1'b0;
    if (hb && !(self < nb)) low = 1'b0;
    risk = 0;
    if (low) begin
      risk = int'(self) + 1;
      if (risk > 15) risk = 15;
      risk_acc = risk_acc + risk;
      if (risk_acc > RISK_CAP) risk_acc = RISK_CAP;
    end
    res.row   = row[CELL_ROW_W-1:0];
    res.col   = col[CELL_COL_W-1:0];
    res.low   = low;
    res.risk  = risk[RISK_ADD_W-1:0];
    res.total = risk_acc[RISK_TOTAL_W-1:0];
    res.done  = done;
    return res;
  endfunction

  // One accepted height beat: decide the cell above, then in the last row the cell
  // to the left, then the final cell itself. keep = 0 advances state only.
  task automatic predict_beat(input logic [HEIGHT_W-1:0] h, input bit keep);
    int                  c_lim;
    int                  r_lim;
    int                  r;
    int                  c;
    logic                last_row;
    logic                last_cell;
    logic [HEIGHT_W-1:0] old1;
    logic [HEIGHT_W-1:0] top;
    logic [HEIGHT_W-1:0] nbr;
    cell_result_t        res;
    c_lim = clamp_size(int'(cols_reg), MAX_COLS);
    r_lim = clamp_size(int'(rows_reg), MAX_ROWS_P);
    if (col_pos >= c_lim || row_pos >= r_lim) restart_grid();
    r = row_pos;
    c = col_pos;
    last_row  = (r + 1 == r_lim);
    last_cell = last_row && (c + 1 == c_lim);
    old1 = line_one[c];
    top  = line_two[c];
    if (r >= 1) begin
      nbr = (c + 1 < c_lim) ? line_one[c + 1] : '0;
      res = judge_cell(r - 1, c, old1, r >= 2, top, c >= 1, left_cell,
                       c + 1 < c_lim, nbr, 1'b1, h, 1'b0);
      if (keep) expect_cell(res);
    end
    if (last_row && c >= 1) begin
      nbr = (c >= 2) ? line_one[c - 2] : '0;
      res = judge_cell(r, c - 1, line_one[c - 1], r >= 1, line_two[c - 1], c >= 2, nbr,
                       1'b1, h, 1'b0, '0, 1'b0);
      if (keep) expect_cell(res);
    end
    line_two[c] = old1;
    line_one[c] = h;
    left_cell   = old1;
    if (last_cell) begin
      nbr = (c >= 1) ? line_one[c - 1] : '0;
      res = judge_cell(r, c, h, r >= 1, old1, c >= 1, nbr, 1'b0, '0, 1'b0, '0, 1'b1);
      if (keep) expect_cell(res);
      restart_grid();
    end else begin
      c++;
      if (c >= c_lim) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v, input cell_result_t want);
    if (got !== want_v)
      report_mismatch($sformatf("cell (%0d,%0d) %s: got %0d, want %0d",
                                want.row, want.col, name, got, want_v));
  endtask

  task automatic check_result();
    cell_result_t want;
    if (pending_cells.size() == 0) begin
      report_mismatch($sformatf("result with none expected: cell (%0d,%0d)",
                                out_cell_row, out_cell_column));
      return;
    end
    want = pending_cells.pop_front();
    compare_field("cell_row", 32'(out_cell_row), 32'(want.row), want);
    compare_field("cell_column", 32'(out_cell_column), 32'(want.col), want);
    compare_field("is_low_point", 32'(out_is_low_point), 32'(want.low), want);
    compare_field("risk_added", 32'(out_risk_added), 32'(want.risk), want);
    compare_field("risk_total", 32'(out_risk_total), 32'(want.total), want);
    compare_field("grid_done", 32'(out_grid_done), 32'(want.done), want);
  endtask

  // Input beats are predicted first, then the output beat of the same edge is
  // checked. Both handshakes are sampled with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_beat(in_height, beat_typed_n < 0);
        if (beat_typed_n == 1) expect_cell(beat_typed);
      end
      if (out_valid && out_ready) check_result();
    end
  end

  // Receiver: random stalls per the current mode, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side; every task is entered and left just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [HEIGHT_W-1:0] h, input int typed_n,
                           input cell_result_t typed);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_height    <= h;
    beat_typed_n = typed_n;
    beat_typed   = typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait out every expected beat, then the pipeline latency, since
  // the last beats of a partial grid may still be in flight without a result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (LAT_WAIT) @(negedge clk);
  endtask

  // Write strobe is one cycle wide with a gap after it; the predictor takes the
  // write now because nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_IDX_COLS) cols_reg = data[CFG_COLS_W-1:0];
    else rows_reg = data[CFG_ROWS_W-1:0];
    restart_grid();
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 49; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 49; end
      IDLE_BOTH: begin send_pct = 22; recv_pct = 22; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t s;
    s.kind    = ROW_CFG;
    s.idx     = idx;
    s.data    = data;
    s.height  = '0;
    s.typed_n = -1;
    s.typed   = no_typed;
    directed  = {directed, s};
  endtask

  // typed_n = 1 types in a lone-cell grid result, whose total equals its risk.
  task automatic add_beat(input logic [HEIGHT_W-1:0] h, input int typed_n,
                          input int risk_typed);
    stim_row_t s;
    s.kind        = ROW_BEAT;
    s.idx         = '0;
    s.data        = '0;
    s.height      = h;
    s.typed_n     = typed_n;
    s.typed.row   = '0;
    s.typed.col   = '0;
    s.typed.low   = 1'b1;
    s.typed.risk  = risk_typed[RISK_ADD_W-1:0];
    s.typed.total = risk_typed[RISK_TOTAL_W-1:0];
    s.typed.done  = 1'b1;
    directed      = {directed, s};
  endtask

  initial begin
    int                    phase;
    int                    random_beats;
    int                    cells;
    int                    n_beats;
    int                    top_h;
    int                    half;
    logic [CFG_DATA_W-1:0] cols_data;
    logic [CFG_DATA_W-1:0] rows_data;

    // Predictor comes up in the reset grid, 256 x 4096, buffers zero.
    for (int i = 0; i < MAX_COLS; i++) begin
      line_two[i] = '0;
      line_one[i] = '0;
    end
    cols_reg = COLS_RESET[CFG_COLS_W-1:0];
    rows_reg = ROWS_RESET[CFG_ROWS_W-1:0];
    restart_grid();

    // After reset the grid is 256 wide: first-row beats decide nothing yet.
    add_beat(4'd5, 0, 0);
    add_beat(4'd10, 0, 0);
    // Sizes of zero act as one: each beat is a whole lone-cell grid, always a low
    // point; height 15 saturates the risk at 15.
    add_cfg(CFG_IDX_COLS, 13'd0);
    add_cfg(CFG_IDX_ROWS, 13'd0);
    add_beat(4'd0, 1, 1);
    add_beat(4'd9, 1, 10);
    add_beat(4'd15, 1, 15);
    // 3 x 2 grid; junk above bit 8 of the column write is dropped. Equal
    // neighbors (3,3) must not count as low.
    add_cfg(CFG_IDX_COLS, 13'h1E03);
    add_cfg(CFG_IDX_ROWS, 13'd2);
    add_beat(4'd9, -1, 0);
    add_beat(4'd3, -1, 0);
    add_beat(4'd3, -1, 0);
    add_beat(4'd2, -1, 0);
    add_beat(4'd9, -1, 0);
    add_beat(4'd0, -1, 0);
    // Single row: every cell but the last decided one beat late, final beat yields two.
    add_cfg(CFG_IDX_ROWS, 13'd1);
    add_beat(4'd4, -1, 0);
    add_beat(4'd4, -1, 0);
    add_beat(4'd1, -1, 0);
    // Single column, three rows.
    add_cfg(CFG_IDX_COLS, 13'd1);
    add_cfg(CFG_IDX_ROWS, 13'd3);
    add_beat(4'd2, -1, 0);
    add_beat(4'd1, -1, 0);
    add_beat(4'd2, -1, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idle(IDLE_NONE);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_beat(directed[i].height, directed[i].typed_n, directed[i].typed);
      end
    end

    // Random phases. The first two hit the size limits (oversize writes clamp)
    // on partial grids; the rest are small grids, mostly whole ones with an
    // occasional broken tail. Idle mode rotates with the phase.
    phase        = 0;
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      if (phase == 0) begin
        cols_data = '1;        // 511 after masking -> 256 columns
        rows_data = 13'd1;
        n_beats   = 24;
      end else if (phase == 1) begin
        cols_data = 13'd1;
        rows_data = '1;        // 8191 -> 4096 rows
        n_beats   = 24;
      end else begin
        cols_data = CFG_DATA_W'($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0)
          cols_data = cols_data | CFG_DATA_W'($urandom_range(1, 15) << CFG_COLS_W);
        rows_data = CFG_DATA_W'($urandom_range(0, 6));
        cells = clamp_size(int'(cols_data[CFG_COLS_W-1:0]), MAX_COLS) *
                clamp_size(int'(rows_data), MAX_ROWS_P);
        n_beats = cells * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n_beats = n_beats + $urandom_range(1, cells);
        if (n_beats > RANDOM_BEATS - random_beats) n_beats = RANDOM_BEATS - random_beats;
        if ((phase == 3 || phase == 4) && n_beats < 30) n_beats = 30;
      end
      wait_idle();
      set_idle(idle_mode_t'(phase % 4));
      write_reg(CFG_IDX_COLS, cols_data);
      write_reg(CFG_IDX_ROWS, rows_data);

      // mostly digits, sometimes a narrow range for ties, sometimes full 4 bits
      if ($urandom_range(0, 3) == 0) top_h = 15;
      else if ($urandom_range(0, 3) == 0) top_h = 2;
      else top_h = 9;

      // Long receiver hold-off while the sender keeps offering: in_ready must drop.
      if (phase == 4) hold_request = 1'b1;
      half = n_beats / 2;
      for (int k = 0; k < n_beats; k++) begin
        // sender pause mid-grid until all outstanding results are out
        if (phase == 3 && k == half) wait_idle();
        send_beat(HEIGHT_W'($urandom_range(0, top_h)), -1, no_typed);
      end
      random_beats = random_beats + n_beats;
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard: stops a run that never finishes and reports it as failing.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/glmr_pkg.sv
rtl/glmr_front.sv
rtl/glmr_queue.sv
rtl/glmr_back.sv
rtl/grid_local_minimum_risk_sum_core.sv
rtl/glmr_checker.sv
tb/sv/tb_top.sv
